FILE: hw/rtl/sckf_pkg.sv
// Shared types, constants and key tables for the scancode decoder with key FIFO.
`timescale 1ns / 1ps
`default_nettype none

package sckf_pkg;

  // Key FIFO geometry.
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_UP    = 3'd0,
    CFG_CODE_DOWN  = 3'd1,
    CFG_CODE_LEFT  = 3'd2,
    CFG_CODE_RIGHT = 3'd3,
    CFG_CODE_TAB   = 3'd4
  } cfg_idx_e;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Scancode constants.
  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [7:0] SC_LSHIFT  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_CTRL    = 8'h1D;
  localparam logic [7:0] SC_UP      = 8'h48;
  localparam logic [7:0] SC_DOWN    = 8'h50;
  localparam logic [7:0] SC_LEFT    = 8'h4B;
  localparam logic [7:0] SC_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_TAB     = 8'h0F;
  localparam logic [7:0] SC_ENTER   = 8'h1C;
  localparam logic [7:0] SC_BKSP    = 8'h0E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BKSP    = 8'h08;
  localparam logic [7:0] CTRL_MASK  = 8'h1F;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_CODE_UP    = 8'd128;
  localparam logic [7:0] RST_CODE_DOWN  = 8'd129;
  localparam logic [7:0] RST_CODE_LEFT  = 8'd130;
  localparam logic [7:0] RST_CODE_RIGHT = 8'd131;
  localparam logic [7:0] RST_CODE_TAB   = 8'd9;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] scancode;
    logic       foreground_active;
    logic       reader_blocked;
  } in_item_t;

  typedef struct packed {
    logic       shell_valid;
    logic [7:0] shell_char;
    logic       wake_reader;
    logic       read_valid;
    logic [7:0] read_char;
  } out_item_t;

  typedef struct packed {
    logic [7:0] code_up;
    logic [7:0] code_down;
    logic [7:0] code_left;
    logic [7:0] code_right;
    logic [7:0] code_tab;
  } cfg_t;

  // Requests from the top level to the key FIFO for one advancing item.
  typedef struct packed {
    logic       push;
    logic [7:0] wdata;
    logic       pop;
    logic       flush;
  } fifo_req_t;

  // Unshifted meaning of a make code.
  function automatic logic [7:0] plain_map(input logic [6:0] key);
    logic [7:0] c;
    c = 8'h00;
    case (key)
      7'h02: c = 8'h31; 7'h03: c = 8'h32; 7'h04: c = 8'h33; 7'h05: c = 8'h34;
      7'h06: c = 8'h35; 7'h07: c = 8'h36; 7'h08: c = 8'h37; 7'h09: c = 8'h38;
      7'h0A: c = 8'h39; 7'h0B: c = 8'h30; 7'h0C: c = 8'h2D; 7'h0D: c = 8'h3D;
      7'h10: c = 8'h71; 7'h11: c = 8'h77; 7'h12: c = 8'h65; 7'h13: c = 8'h72;
      7'h14: c = 8'h74; 7'h15: c = 8'h79; 7'h16: c = 8'h75; 7'h17: c = 8'h69;
      7'h18: c = 8'h6F; 7'h19: c = 8'h70; 7'h1A: c = 8'h5B; 7'h1B: c = 8'h5D;
      7'h1E: c = 8'h61; 7'h1F: c = 8'h73; 7'h20: c = 8'h64; 7'h21: c = 8'h66;
      7'h22: c = 8'h67; 7'h23: c = 8'h68; 7'h24: c = 8'h6A; 7'h25: c = 8'h6B;
      7'h26: c = 8'h6C; 7'h27: c = 8'h3B; 7'h28: c = 8'h27; 7'h29: c = 8'h60;
      7'h2B: c = 8'h5C; 7'h2C: c = 8'h7A; 7'h2D: c = 8'h78; 7'h2E: c = 8'h63;
      7'h2F: c = 8'h76; 7'h30: c = 8'h62; 7'h31: c = 8'h6E; 7'h32: c = 8'h6D;
      7'h33: c = 8'h2C; 7'h34: c = 8'h2E; 7'h35: c = 8'h2F; 7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted meaning of a make code, including the keypad digits.
  function automatic logic [7:0] upper_map(input logic [6:0] key);
    logic [7:0] c;
    c = 8'h00;
    case (key)
      7'h02: c = 8'h21; 7'h03: c = 8'h40; 7'h04: c = 8'h23; 7'h05: c = 8'h24;
      7'h06: c = 8'h25; 7'h07: c = 8'h5E; 7'h08: c = 8'h26; 7'h09: c = 8'h2A;
      7'h0A: c = 8'h28; 7'h0B: c = 8'h29; 7'h0C: c = 8'h5F; 7'h0D: c = 8'h2B;
      7'h10: c = 8'h51; 7'h11: c = 8'h57; 7'h12: c = 8'h45; 7'h13: c = 8'h52;
      7'h14: c = 8'h54; 7'h15: c = 8'h59; 7'h16: c = 8'h55; 7'h17: c = 8'h49;
      7'h18: c = 8'h4F; 7'h19: c = 8'h50; 7'h1A: c = 8'h7B; 7'h1B: c = 8'h7D;
      7'h1E: c = 8'h41; 7'h1F: c = 8'h53; 7'h20: c = 8'h44; 7'h21: c = 8'h46;
      7'h22: c = 8'h47; 7'h23: c = 8'h48; 7'h24: c = 8'h4A; 7'h25: c = 8'h4B;
      7'h26: c = 8'h4C; 7'h27: c = 8'h3A; 7'h28: c = 8'h22; 7'h29: c = 8'h7E;
      7'h2B: c = 8'h7C; 7'h2C: c = 8'h5A; 7'h2D: c = 8'h58; 7'h2E: c = 8'h43;
      7'h2F: c = 8'h56; 7'h30: c = 8'h42; 7'h31: c = 8'h4E; 7'h32: c = 8'h4D;
      7'h33: c = 8'h3C; 7'h34: c = 8'h3E; 7'h35: c = 8'h3F; 7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      7'h47: c = 8'h37; 7'h48: c = 8'h38; 7'h49: c = 8'h39; 7'h4A: c = 8'h2D;
      7'h4B: c = 8'h34; 7'h4C: c = 8'h35; 7'h4D: c = 8'h36; 7'h4E: c = 8'h2B;
      7'h4F: c = 8'h31; 7'h50: c = 8'h32; 7'h51: c = 8'h33; 7'h52: c = 8'h30;
      7'h53: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sckf_decode.sv
// Scancode decoder: modifier and prefix tracking plus make code translation.
`timescale 1ns / 1ps
`default_nettype none

module sckf_decode (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 scan_en_i,
  input  wire  [7:0]          scancode_i,
  input  sckf_pkg::cfg_t      cfg_i,
  output logic                deliver_o,
  output logic [7:0]          code_o
);

  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;
  logic prefix_q, prefix_d;
  logic [6:0] key;
  logic [7:0] base;
  logic [7:0] shifted;

  assign key     = scancode_i[6:0];
  assign base    = sckf_pkg::plain_map(key);
  assign shifted = sckf_pkg::upper_map(key);

  // Translate one scancode byte and work out the next modifier state.
  always_comb begin
    shift_d   = shift_q;
    ctrl_d    = ctrl_q;
    prefix_d  = prefix_q;
    deliver_o = 1'b0;
    code_o    = 8'h00;
    if (scancode_i == sckf_pkg::SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (scancode_i[7]) begin
      // Break code: release modifiers; a prefixed shift release is ignored.
      if (!prefix_q && ({1'b0, key} == sckf_pkg::SC_LSHIFT ||
                        {1'b0, key} == sckf_pkg::SC_RSHIFT)) begin
        shift_d = 1'b0;
      end
      if ({1'b0, key} == sckf_pkg::SC_CTRL) begin
        ctrl_d = 1'b0;
      end
      prefix_d = 1'b0;
    end else if (prefix_q) begin
      // Extended make code: right control and the arrow keys only.
      prefix_d = 1'b0;
      if (scancode_i == sckf_pkg::SC_CTRL) begin
        ctrl_d = 1'b1;
      end else if (scancode_i == sckf_pkg::SC_UP) begin
        deliver_o = 1'b1;
        code_o    = cfg_i.code_up;
      end else if (scancode_i == sckf_pkg::SC_DOWN) begin
        deliver_o = 1'b1;
        code_o    = cfg_i.code_down;
      end else if (scancode_i == sckf_pkg::SC_LEFT) begin
        deliver_o = 1'b1;
        code_o    = cfg_i.code_left;
      end else if (scancode_i == sckf_pkg::SC_RIGHT) begin
        deliver_o = 1'b1;
        code_o    = cfg_i.code_right;
      end
    end else if (scancode_i == sckf_pkg::SC_CTRL) begin
      ctrl_d = 1'b1;
    end else if (scancode_i == sckf_pkg::SC_LSHIFT ||
                 scancode_i == sckf_pkg::SC_RSHIFT) begin
      shift_d = 1'b1;
    end else if (scancode_i == sckf_pkg::SC_TAB) begin
      deliver_o = 1'b1;
      code_o    = cfg_i.code_tab;
    end else if (scancode_i == sckf_pkg::SC_ENTER) begin
      deliver_o = 1'b1;
      code_o    = sckf_pkg::CH_NEWLINE;
    end else if (scancode_i == sckf_pkg::SC_BKSP) begin
      deliver_o = 1'b1;
      code_o    = sckf_pkg::CH_BKSP;
    end else if (ctrl_q) begin
      // Control held: only letters produce a control character.
      if (base >= 8'h61 && base <= 8'h7A) begin
        deliver_o = 1'b1;
        code_o    = base & sckf_pkg::CTRL_MASK;
      end
    end else begin
      code_o    = shift_q ? shifted : base;
      deliver_o = (code_o != 8'h00);
    end
  end

  // Modifier state advances only when a scancode item passes through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (scan_en_i) begin
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sckf_fifo.sv
// Ring key FIFO with a registered read port; holds one less than its depth.
`timescale 1ns / 1ps
`default_nettype none

module sckf_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sckf_pkg::fifo_req_t  req_i,
  output logic                 pop_hit_o,
  output logic [7:0]           rdata_o
);

  localparam int unsigned PtrW = sckf_pkg::PTR_W;

  logic [7:0]      mem [sckf_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW-1:0] wptr_nxt, rptr_nxt;
  logic [7:0]      rdata_q;
  logic            full, empty, do_push;

  // Pointer successors wrap at the last entry.
  assign wptr_nxt = (wptr_q == PtrW'(sckf_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
  assign rptr_nxt = (rptr_q == PtrW'(sckf_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;

  assign full      = (wptr_nxt == rptr_q);
  assign empty     = (wptr_q == rptr_q);
  assign do_push   = req_i.push && !full;
  assign pop_hit_o = req_i.pop && !empty;
  assign rdata_o   = rdata_q;

  // Next pointer values for this item.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = wptr_nxt;
    end
    if (pop_hit_o) begin
      rptr_d = rptr_nxt;
    end else if (req_i.flush) begin
      rptr_d = wptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // Storage write and registered read; a read only happens on a successful pop.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= req_i.wdata;
    end
    if (pop_hit_o) begin
      rdata_q <= mem[rptr_q];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scancode_decoder_with_key_fifo.sv
// Top level: input register, decode and FIFO service, result register.
//
// Usage: each input item carries an operation (scancode byte, read one
// buffered character, or flush), the scancode byte and two flags about the
// foreground process. Every item produces exactly one result item.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. An accepted item sits in the input register until it
// advances, is then decoded and applied to the modifier state and the
// key FIFO, and its result is held in the result register. A new item
// is accepted in every cycle while the receiver does not stall.
// Characters read from the FIFO come straight from the memory's
// registered read port.
// When the receiver stalls, the result register holds; the input register
// keeps accepting until it is full, then the input is stalled.
// Reset clears the modifiers, the FIFO pointers and both valid flags, and
// loads the configuration codes with their defaults; FIFO contents are not
// cleared. Configuration writes take effect on the next edge.
`timescale 1ns / 1ps
`default_nettype none

module scancode_decoder_with_key_fifo (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  sckf_pkg::in_item_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output sckf_pkg::out_item_t                    out_data_o,
  input  wire                                    cfg_we_i,
  input  wire  [sckf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [7:0]                             cfg_data_i
);

  sckf_pkg::cfg_t      cfg_q;
  sckf_pkg::in_item_t  in_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                shell_valid_q, shell_valid_d;
  logic [7:0]          shell_char_q, shell_char_d;
  logic                wake_q, wake_d;
  logic                read_valid_q;
  logic                advance;
  logic                scan_en;
  logic                deliver;
  logic [7:0]          code;
  logic                pop_hit;
  logic [7:0]          rdata;
  sckf_pkg::fifo_req_t fifo_req;
  sckf_pkg::op_e       op;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_up    <= sckf_pkg::RST_CODE_UP;
      cfg_q.code_down  <= sckf_pkg::RST_CODE_DOWN;
      cfg_q.code_left  <= sckf_pkg::RST_CODE_LEFT;
      cfg_q.code_right <= sckf_pkg::RST_CODE_RIGHT;
      cfg_q.code_tab   <= sckf_pkg::RST_CODE_TAB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sckf_pkg::CFG_CODE_UP:    cfg_q.code_up    <= cfg_data_i;
        sckf_pkg::CFG_CODE_DOWN:  cfg_q.code_down  <= cfg_data_i;
        sckf_pkg::CFG_CODE_LEFT:  cfg_q.code_left  <= cfg_data_i;
        sckf_pkg::CFG_CODE_RIGHT: cfg_q.code_right <= cfg_data_i;
        sckf_pkg::CFG_CODE_TAB:   cfg_q.code_tab   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: the stored item advances when the result slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  assign op      = sckf_pkg::op_e'(in_q.operation);
  assign scan_en = advance && (op == sckf_pkg::OP_SCAN);

  sckf_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_en_i  (scan_en),
    .scancode_i (in_q.scancode),
    .cfg_i      (cfg_q),
    .deliver_o  (deliver),
    .code_o     (code)
  );

  // Route a decoded character to the shell or to the key FIFO (foreground codes with bit 7 set are dropped).
  always_comb begin
    shell_valid_d  = 1'b0;
    shell_char_d   = 8'h00;
    wake_d         = 1'b0;
    fifo_req.push  = 1'b0;
    fifo_req.wdata = code;
    fifo_req.pop   = advance && (op == sckf_pkg::OP_READ);
    fifo_req.flush = advance && (op == sckf_pkg::OP_FLUSH);
    if (scan_en && deliver) begin
      if (!in_q.foreground_active) begin
        shell_valid_d = 1'b1;
        shell_char_d  = code;
      end else if (!code[7]) begin
        fifo_req.push = 1'b1;
        wake_d        = in_q.reader_blocked;
      end
    end
  end

  sckf_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .pop_hit_o (pop_hit),
    .rdata_o   (rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      shell_valid_q <= shell_valid_d;
      shell_char_q  <= shell_char_d;
      wake_q        <= wake_d;
      read_valid_q  <= pop_hit;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.shell_valid = shell_valid_q;
  assign out_data_o.shell_char  = shell_char_q;
  assign out_data_o.wake_reader = wake_q;
  assign out_data_o.read_valid  = read_valid_q;
  assign out_data_o.read_char   = read_valid_q ? rdata : 8'h00;

endmodule

`default_nettype wire
